// File: rtl/mise_pkg.sv
// Package for the MIPS integer subset executor: field widths, opcodes,
// instruction classes and the queue entry shared by front and back.
// No dependencies.
package mise_pkg;

  localparam int GPR_W       = 64;
  localparam int NUM_GPR     = 32;
  localparam int REG_AW      = 5;
  localparam int WORD_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0] START_PC_RESET = 32'h1FC0_0000;
  localparam logic [WORD_W-1:0] PC_STEP        = 32'd4;
  localparam logic [WORD_W-1:0] COUNT_STEP     = 32'd2;

  localparam logic [5:0] OPC_BNE   = 6'd5;
  localparam logic [5:0] OPC_ADDIU = 6'd9;
  localparam logic [5:0] OPC_ANDI  = 6'd12;
  localparam logic [5:0] OPC_ORI   = 6'd13;
  localparam logic [5:0] OPC_LUI   = 6'd15;
  localparam logic [5:0] OPC_BEQL  = 6'd20;
  localparam logic [5:0] OPC_BNEL  = 6'd21;
  localparam logic [5:0] OPC_LW    = 6'd35;
  localparam logic [5:0] OPC_SW    = 6'd43;

  localparam logic [1:0] MREQ_NONE  = 2'd0;
  localparam logic [1:0] MREQ_READ  = 2'd1;
  localparam logic [1:0] MREQ_WRITE = 2'd2;

  typedef enum logic [3:0] {
    CLS_BNE,
    CLS_BEQL,
    CLS_BNEL,
    CLS_ADDIU,
    CLS_ANDI,
    CLS_ORI,
    CLS_LUI,
    CLS_LW,
    CLS_SW,
    CLS_FAULT,
    CLS_LDATA
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [WORD_W-1:0] word;
  } qent_t;

  function automatic cls_t classify(input logic is_ldata, input logic [5:0] opc);
    cls_t c;
    c = CLS_FAULT;
    if (is_ldata) begin
      c = CLS_LDATA;
    end else begin
      case (opc)
        OPC_BNE:   c = CLS_BNE;
        OPC_BEQL:  c = CLS_BEQL;
        OPC_BNEL:  c = CLS_BNEL;
        OPC_ADDIU: c = CLS_ADDIU;
        OPC_ANDI:  c = CLS_ANDI;
        OPC_ORI:   c = CLS_ORI;
        OPC_LUI:   c = CLS_LUI;
        OPC_LW:    c = CLS_LW;
        OPC_SW:    c = CLS_SW;
        default:   c = CLS_FAULT;
      endcase
    end
    return c;
  endfunction

endpackage

// File: rtl/mise_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module mise_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

// File: rtl/mise_front.sv
// Front end: accepts input transactions, classifies them and queues them
// for the back end. Depends on mise_pkg.
module mise_front #(
  parameter int QDEPTH = mise_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [63:0]     in_tdata,
  input  logic            in_tuser,
  input  logic            pop,
  output mise_pkg::qent_t head,
  output logic            head_vld
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  mise_pkg::qent_t q_r [QDEPTH];
  mise_pkg::qent_t ent;
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, do_pop;

  assign ent.cls  = mise_pkg::classify(in_tuser, in_tdata[31:26]);
  assign ent.word = in_tuser ? in_tdata[63:32] : in_tdata[31:0];

  assign in_tready = (cnt_r != CW'(QDEPTH));
  assign push      = in_tvalid & in_tready;
  assign head_vld  = (cnt_r != '0);
  assign do_pop    = pop & head_vld;
  assign head      = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

endmodule

// File: rtl/mise_back.sv
// Back end: register file read, execute, architectural state and output
// register. Depends on mise_pkg and mise_ram.
module mise_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wen,
  input  logic [31:0]     cfg_wdata,
  input  mise_pkg::qent_t head,
  input  logic            head_vld,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [127:0]    out_tdata,
  output logic [2:0]      out_tuser
);

  localparam int AW = mise_pkg::REG_AW;
  localparam int GW = mise_pkg::GPR_W;
  localparam int WW = mise_pkg::WORD_W;

  logic                 adv;
  logic [AW-1:0]        ra, rb;
  logic [GW-1:0]        qa, qb;

  mise_pkg::qent_t      ex_r;
  logic                 ex_vld_r;
  logic                 va_r, vb_r;
  logic                 fwd_we_r;
  logic [AW-1:0]        fwd_wa_r;
  logic [GW-1:0]        fwd_wd_r;
  logic [mise_pkg::NUM_GPR-1:0] gvld_r;

  logic [WW-1:0]        pc_r, pc_nxt, bt_r, bt_nxt, cnt_r, cnt_nxt;
  logic                 bp_r, bp_nxt, lp_r, lp_nxt;
  logic [AW-1:0]        ld_r, ld_nxt;

  logic [AW-1:0]        ex_rs, ex_rt;
  logic [15:0]          imm;
  logic [GW-1:0]        opa, opb;
  logic [WW-1:0]        imm_sx, sum, btarget, seq_pc;
  logic                 eq;

  logic                 gpr_we, ram_we, taken, nullify, fault;
  logic [AW-1:0]        wa;
  logic [GW-1:0]        wd;
  logic [1:0]           req;
  logic [WW-1:0]        addr, wdata;

  logic                 out_vld_r, out_fault_r;
  logic [1:0]           out_req_r;
  logic [WW-1:0]        out_pc_r, out_addr_r, out_wdata_r, out_cnt_r;

  assign adv = !out_vld_r || out_tready;
  assign pop = adv & head_vld;
  assign ra  = head.word[25:21];
  assign rb  = head.word[20:16];

  mise_ram #(
    .WIDTH (GW),
    .DEPTH (mise_pkg::NUM_GPR)
  ) u_gpr (
    .clk     (clk),
    .re      (adv),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (qa),
    .rdata_b (qb),
    .we      (ram_we),
    .waddr   (wa),
    .wdata   (wd)
  );

  assign ex_rs   = ex_r.word[25:21];
  assign ex_rt   = ex_r.word[20:16];
  assign imm     = ex_r.word[15:0];
  assign opa     = (fwd_we_r && fwd_wa_r == ex_rs) ? fwd_wd_r : (va_r ? qa : '0);
  assign opb     = (fwd_we_r && fwd_wa_r == ex_rt) ? fwd_wd_r : (vb_r ? qb : '0);
  assign imm_sx  = {{16{imm[15]}}, imm};
  assign sum     = opa[WW-1:0] + imm_sx;
  assign btarget = pc_r + mise_pkg::PC_STEP + {imm_sx[WW-3:0], 2'b00};
  assign seq_pc  = bp_r ? bt_r : pc_r + mise_pkg::PC_STEP;
  assign eq      = (opa == opb);
  assign ram_we  = gpr_we & adv;

  always_comb begin
    pc_nxt  = pc_r;
    bp_nxt  = bp_r;
    bt_nxt  = bt_r;
    lp_nxt  = lp_r;
    ld_nxt  = ld_r;
    cnt_nxt = cnt_r;
    gpr_we  = 1'b0;
    wa      = ex_rt;
    wd      = '0;
    req     = mise_pkg::MREQ_NONE;
    addr    = '0;
    wdata   = '0;
    fault   = 1'b0;
    taken   = 1'b0;
    nullify = 1'b0;
    if (ex_vld_r) begin
      if (ex_r.cls == mise_pkg::CLS_LDATA) begin
        if (lp_r) begin
          gpr_we = (ld_r != '0);
          wa     = ld_r;
          wd     = {{(GW-WW){ex_r.word[WW-1]}}, ex_r.word};
          lp_nxt = 1'b0;
        end
      end else if (!lp_r) begin
        case (ex_r.cls)
          mise_pkg::CLS_BNE: begin
            taken = !eq;
          end
          mise_pkg::CLS_BEQL: begin
            taken   = eq;
            nullify = !eq;
          end
          mise_pkg::CLS_BNEL: begin
            taken   = !eq;
            nullify = eq;
          end
          mise_pkg::CLS_ADDIU: begin
            gpr_we = (ex_rt != '0);
            wd     = {{(GW-WW){sum[WW-1]}}, sum};
          end
          mise_pkg::CLS_ANDI: begin
            gpr_we = (ex_rt != '0);
            wd     = opa & {{(GW-16){1'b0}}, imm};
          end
          mise_pkg::CLS_ORI: begin
            gpr_we = (ex_rt != '0);
            wd     = opa | {{(GW-16){1'b0}}, imm};
          end
          mise_pkg::CLS_LUI: begin
            gpr_we = (ex_rt != '0);
            wd     = {{(GW-WW){imm[15]}}, imm, 16'h0000};
          end
          mise_pkg::CLS_LW: begin
            req    = mise_pkg::MREQ_READ;
            addr   = sum;
            lp_nxt = 1'b1;
            ld_nxt = ex_rt;
          end
          mise_pkg::CLS_SW: begin
            req   = mise_pkg::MREQ_WRITE;
            addr  = sum;
            wdata = opb[WW-1:0];
          end
          default: begin
            fault = 1'b1;
          end
        endcase
        if (!fault) begin
          pc_nxt  = nullify ? seq_pc + mise_pkg::PC_STEP : seq_pc;
          bp_nxt  = taken;
          cnt_nxt = cnt_r + mise_pkg::COUNT_STEP;
          if (taken) begin
            bt_nxt = btarget;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= mise_pkg::START_PC_RESET;
      bp_r   <= 1'b0;
      bt_r   <= '0;
      lp_r   <= 1'b0;
      ld_r   <= '0;
      cnt_r  <= '0;
      gvld_r <= '0;
    end else begin
      if (cfg_wen) begin
        pc_r <= cfg_wdata;
        bp_r <= 1'b0;
        lp_r <= 1'b0;
      end else if (adv && ex_vld_r) begin
        pc_r  <= pc_nxt;
        bp_r  <= bp_nxt;
        bt_r  <= bt_nxt;
        lp_r  <= lp_nxt;
        ld_r  <= ld_nxt;
        cnt_r <= cnt_nxt;
      end
      if (ram_we) begin
        gvld_r[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r  <= 1'b0;
      fwd_we_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      ex_vld_r  <= head_vld;
      fwd_we_r  <= ram_we;
      out_vld_r <= ex_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r        <= head;
      va_r        <= gvld_r[ra];
      vb_r        <= gvld_r[rb];
      fwd_wa_r    <= wa;
      fwd_wd_r    <= wd;
      out_pc_r    <= pc_nxt;
      out_req_r   <= req;
      out_addr_r  <= addr;
      out_wdata_r <= wdata;
      out_fault_r <= fault;
      out_cnt_r   <= cnt_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_cnt_r, out_wdata_r, out_addr_r, out_pc_r};
  assign out_tuser  = {out_fault_r, out_req_r};

  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> wa != '0)
    else $error("write to r0 reached the register file");

  a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> gvld_r[fwd_wa_r])
    else $error("register valid bit not set after write");

  a_fault_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_fault_r |-> out_req_r == mise_pkg::MREQ_NONE && out_addr_r == '0)
    else $error("faulting transaction issued a memory request");

  a_lw_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ex_vld_r && ex_r.cls == mise_pkg::CLS_LW && !lp_r && !cfg_wen |=> lp_r)
    else $error("load did not mark a pending load");

endmodule

// File: rtl/mips_integer_subset_executor.sv
// Top level of the MIPS integer subset executor: front end, queue and back
// end. Depends on mise_pkg, mise_front, mise_back.
//
//   port group | dir | contents
//   in_*       | in  | tuser: op; tdata: instr_word [31:0], load_data [63:32]
//   out_*      | out | tuser: mem_req, fault; tdata: fetch_pc, mem_addr,
//              |     |        mem_wdata, count_value
//   cfg_*      | in  | start_pc write, restarts fetch
//
// One transaction per cycle sustained while the output is not stalled; from input
// accept to result valid: queue write, then pop with register file read into
// execute, then execute into the output register. The register file read port
// is registered; a write from the execute stage is forwarded to the next instruction.
// Reset is synchronous: queue empty, registers read zero, pc = 0x1FC00000.
// A stalled output holds the back end; the queue keeps accepting until full.
module mips_integer_subset_executor #(
  parameter int QDEPTH = mise_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // instr_word [31:0], load_data [63:32]
  input  logic         in_tuser,   // op [0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // fetch_pc, mem_addr, mem_wdata, count_value
  output logic [2:0]   out_tuser,  // mem_req [1:0], fault [2]
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata   // start_pc
);

  mise_pkg::qent_t head;
  logic            head_vld;
  logic            pop;

  mise_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .pop       (pop),
    .head      (head),
    .head_vld  (head_vld)
  );

  mise_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .head_vld   (head_vld),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
